// File: rtl/core/assert_macros.svh
// Assertion helpers included by hangar_mode_supervisor.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/hms_pkg.sv
package hms_pkg;

	typedef enum logic [2:0] {
		MODE_INIT     = 3'd0,
		MODE_IDLE     = 3'd1,
		MODE_TAKEOFF  = 3'd2,
		MODE_OUT      = 3'd3,
		MODE_LANDING  = 3'd4,
		MODE_PREALARM = 3'd5,
		MODE_ALARM    = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		REG_CRIT_TEMP = 2'd0,
		REG_CRIT_TIME = 2'd1,
		REG_WARN_TEMP = 2'd2,
		REG_WARN_TIME = 2'd3
	} reg_idx_t;

	localparam logic signed [15:0] CRIT_TEMP_RST = 16'sd6000;
	localparam logic [31:0]        CRIT_TIME_RST = 32'd5000;
	localparam logic signed [15:0] WARN_TEMP_RST = 16'sd4000;
	localparam logic [31:0]        WARN_TIME_RST = 32'd5000;

	typedef struct packed {
		logic signed [15:0] temp_sample;
		logic [31:0]        now_ms;
		logic               advance;
	} step_in_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [15:0] temp_report;
	} step_out_t;

endpackage

// File: rtl/core/hangar_mode_supervisor.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_ready       step_in_t  (temp_sample, now_ms, advance)
// out       output     out_valid / out_ready     step_out_t (mode, temp_report)
// apb       input      psel/penable/pwrite       paddr[3:2] selects one of four registers
//
// An input transaction passes two registers on its way to the result: the input register,
// then the mode and timer update, which lands in the result register.
// One transaction is taken every cycle unless out_ready stalls the result; the state update keeps that rate.
// Reset puts the mode in init, the saved mode in idle and both timers disarmed.
// A stalled result holds in the output register while the input register still fills.
`include "assert_macros.svh"

module hangar_mode_supervisor import hms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  step_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output step_out_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic signed [15:0] crit_temp_q, warn_temp_q;
	logic [31:0]        crit_time_q, warn_time_q;

	step_in_t  in_s1;
	logic      valid_s1;
	step_out_t out_q;
	logic      out_valid_q;

	mode_t       mode_q, saved_mode_q;
	logic        crit_armed_q, warn_armed_q;
	logic [31:0] crit_start_q, warn_start_q;

	mode_t       mode_d, saved_mode_d;
	logic        crit_armed_d, warn_armed_d;
	logic [31:0] crit_start_d, warn_start_d;

	logic        step_en, cfg_wr;
	reg_idx_t    cfg_idx;
	logic        crit_hot, crit_fire, warn_hot, warn_fire;
	logic [31:0] crit_elapsed, warn_elapsed;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_CRIT_TEMP: prdata = {{16{crit_temp_q[15]}}, crit_temp_q};
			REG_CRIT_TIME: prdata = crit_time_q;
			REG_WARN_TEMP: prdata = {{16{warn_temp_q[15]}}, warn_temp_q};
			REG_WARN_TIME: prdata = warn_time_q;
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_temp_q <= CRIT_TEMP_RST;
			crit_time_q <= CRIT_TIME_RST;
			warn_temp_q <= WARN_TEMP_RST;
			warn_time_q <= WARN_TIME_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CRIT_TEMP: crit_temp_q <= pwdata[15:0];
				REG_CRIT_TIME: crit_time_q <= pwdata;
				REG_WARN_TEMP: warn_temp_q <= pwdata[15:0];
				REG_WARN_TIME: warn_time_q <= pwdata;
				default: ;
			endcase
		end
	end

	// The step runs when the input register holds an item and the result slot frees up.
	assign step_en   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || step_en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	assign crit_elapsed = in_s1.now_ms - crit_start_q;
	assign warn_elapsed = in_s1.now_ms - warn_start_q;

	assign crit_hot  = (mode_q != MODE_ALARM) && (in_s1.temp_sample > crit_temp_q);
	assign crit_fire = crit_hot && crit_armed_q && (crit_elapsed > crit_time_q);
	assign warn_hot  = !crit_fire && (mode_q == MODE_IDLE || mode_q == MODE_OUT)
		&& (in_s1.temp_sample > warn_temp_q);
	assign warn_fire = warn_hot && warn_armed_q && (warn_elapsed > warn_time_q);

	always_comb begin
		mode_d       = mode_q;
		saved_mode_d = saved_mode_q;
		crit_armed_d = crit_armed_q;
		crit_start_d = crit_start_q;
		warn_armed_d = warn_armed_q;
		warn_start_d = warn_start_q;

		if (crit_hot && !crit_armed_q) begin
			crit_armed_d = 1'b1;
			crit_start_d = in_s1.now_ms;
		end
		if (warn_hot && !warn_armed_q) begin
			warn_armed_d = 1'b1;
			warn_start_d = in_s1.now_ms;
		end

		priority if (crit_fire) begin
			saved_mode_d = mode_q;
			mode_d       = MODE_ALARM;
		end else if (warn_fire) begin
			saved_mode_d = mode_q;
			mode_d       = MODE_PREALARM;
		end else if (in_s1.advance) begin
			unique case (mode_q)
				MODE_INIT:     mode_d = MODE_IDLE;
				MODE_IDLE:     mode_d = MODE_TAKEOFF;
				MODE_TAKEOFF:  mode_d = MODE_OUT;
				MODE_OUT:      mode_d = MODE_LANDING;
				MODE_LANDING:  mode_d = MODE_IDLE;
				MODE_PREALARM: begin
					mode_d       = saved_mode_q;
					warn_armed_d = 1'b0;
					saved_mode_d = MODE_IDLE;
				end
				default: begin
					mode_d       = saved_mode_q;
					crit_armed_d = 1'b0;
					saved_mode_d = MODE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_INIT;
			saved_mode_q <= MODE_IDLE;
			crit_armed_q <= 1'b0;
			warn_armed_q <= 1'b0;
			crit_start_q <= 32'd0;
			warn_start_q <= 32'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (step_en) begin
				mode_q       <= mode_d;
				saved_mode_q <= saved_mode_d;
				crit_armed_q <= crit_armed_d;
				warn_armed_q <= warn_armed_d;
				crit_start_q <= crit_start_d;
				warn_start_q <= warn_start_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_q.mode        <= mode_d;
			out_q.temp_report <= in_s1.temp_sample;
		end
	end

	// Critical expiry from pre-alarm saves pre-alarm, so only alarm can never be saved.
	`ASSERT_NEXT(a_crit_fire_alarm, step_en && crit_fire,
		mode_q == MODE_ALARM && crit_armed_q, "critical expiry did not enter alarm")
	`ASSERT_NEXT(a_leave_alarm, step_en && mode_q == MODE_ALARM && in_s1.advance,
		!crit_armed_q && saved_mode_q == MODE_IDLE, "leaving alarm left timer armed")
	`ASSERT_CLK(a_saved_mode_normal, saved_mode_q != MODE_ALARM, "saved mode holds alarm")

endmodule

// File: verif/hangar_mode_supervisor_tb.sv
`timescale 1ns / 1ps

module hangar_mode_supervisor_tb;
	import hms_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 200;
	localparam int ITEMS_PER_PHASE = 106;

	// Predicts the mode sequence and holds the results still to come out of the block.
	class mode_scoreboard;
		step_out_t          expected_q[$];
		logic signed [15:0] crit_temp;
		logic [31:0]        crit_time;
		logic signed [15:0] warn_temp;
		logic [31:0]        warn_time;
		mode_t              mode;
		mode_t              saved;
		bit                 crit_armed;
		bit                 warn_armed;
		logic [31:0]        crit_start;
		logic [31:0]        warn_start;
		int                 mismatches;
		int                 checked;
		int                 alarms;
		int                 prealarms;

		function new();
			crit_temp = CRIT_TEMP_RST;
			crit_time = CRIT_TIME_RST;
			warn_temp = WARN_TEMP_RST;
			warn_time = WARN_TIME_RST;
			mode = MODE_INIT;
			saved = MODE_IDLE;
			crit_armed = 1'b0;
			warn_armed = 1'b0;
			crit_start = '0;
			warn_start = '0;
			mismatches = 0;
			checked = 0;
			alarms = 0;
			prealarms = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_CRIT_TEMP: crit_temp = value[15:0];
				REG_CRIT_TIME: crit_time = value;
				REG_WARN_TEMP: warn_temp = value[15:0];
				REG_WARN_TIME: warn_time = value;
				default: ;
			endcase
		endfunction

		function void note_input(step_in_t x);
			logic signed [15:0] t;
			logic [31:0]        now;
			logic [31:0]        elapsed;
			mode_t              cur;
			bit                 fired;
			step_out_t          r;
			t = x.temp_sample;
			now = x.now_ms;
			cur = mode;
			fired = 1'b0;

			if (cur != MODE_ALARM && t > crit_temp) begin
				elapsed = now - crit_start;
				if (!crit_armed) begin
					crit_armed = 1'b1;
					crit_start = now;
				end else if (elapsed > crit_time) begin
					saved = cur;
					mode = MODE_ALARM;
					fired = 1'b1;
					alarms++;
				end
			end

			if (!fired && (cur == MODE_IDLE || cur == MODE_OUT) && t > warn_temp) begin
				elapsed = now - warn_start;
				if (!warn_armed) begin
					warn_armed = 1'b1;
					warn_start = now;
				end else if (elapsed > warn_time) begin
					saved = cur;
					mode = MODE_PREALARM;
					fired = 1'b1;
					prealarms++;
				end
			end

			if (!fired && x.advance) begin
				case (cur)
					MODE_INIT:    mode = MODE_IDLE;
					MODE_IDLE:    mode = MODE_TAKEOFF;
					MODE_TAKEOFF: mode = MODE_OUT;
					MODE_OUT:     mode = MODE_LANDING;
					MODE_LANDING: mode = MODE_IDLE;
					MODE_PREALARM: begin
						mode = saved;
						warn_armed = 1'b0;
						warn_start = '0;
						saved = MODE_IDLE;
					end
					default: begin
						mode = saved;
						crit_armed = 1'b0;
						crit_start = '0;
						saved = MODE_IDLE;
					end
				endcase
			end

			r.mode = mode;
			r.temp_report = t;
			expected_q.push_back(r);
		endfunction

		function void check_result(step_out_t got);
			step_out_t want;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing outstanding: mode %0d temp %0d",
						checked, got.mode, got.temp_report);
				return;
			end
			want = expected_q.pop_front();
			if (got.mode !== want.mode || got.temp_report !== want.temp_report) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected mode %0d temp %0d, got mode %0d temp %0d",
						checked, want.mode, want.temp_report, got.mode, got.temp_report);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	step_in_t    in_data;
	logic        out_valid;
	logic        out_ready;
	step_out_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mode_scoreboard sb = new();

	int  cycles = 0;
	int  sent = 0;
	int  phases = 0;
	int  send_idle_pct = 20;
	int  recv_idle_pct = 73;
	bit  hold_req = 1'b0;
	logic [31:0] clock_ms = '0;

	hangar_mode_supervisor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycles, sb.expected_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Both transactions are sampled at the edge, before any driver updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (in_valid && in_ready)
				sb.note_input(in_data);
		end
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic step_in_t make_step(int t, logic [31:0] now, bit adv);
		step_in_t x;
		x.temp_sample = t[15:0];
		x.now_ms = now;
		x.advance = adv;
		return x;
	endfunction

	task automatic send_item(step_in_t x);
		int gaps;
		gaps = 0;
		if (sent < 190) begin
			send_idle_pct = 20;
			recv_idle_pct = 73;
		end else if (sent < 380) begin
			send_idle_pct = 73;
			recv_idle_pct = 20;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while (gaps < 30 && $urandom_range(99) < send_idle_pct)
			gaps++;
		if (gaps > 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// Stops offering and waits until every predicted result has been checked.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic run_phase(int ct, logic [31:0] ctime, int wt, logic [31:0] wtime,
			bit with_hold, bit with_pause);
		int          t;
		int          thr;
		int          span;
		logic [31:0] shortest;
		int unsigned pick;
		drain();
		reg_write(REG_CRIT_TEMP, ct);
		reg_write(REG_CRIT_TIME, ctime);
		reg_write(REG_WARN_TEMP, wt);
		reg_write(REG_WARN_TIME, wtime);
		phases++;
		shortest = (ctime < wtime) ? ctime : wtime;
		span = (shortest > 32'd8000) ? 4000 : int'(shortest / 2) + 20;
		for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
			if (with_hold && k == 20)
				hold_req = 1'b1;
			if (with_pause && k == ITEMS_PER_PHASE / 2)
				drain();
			pick = $urandom_range(99);
			if (pick < 8) begin
				t = int'($urandom_range(65535)) - 32768;
			end else begin
				thr = (pick < 54) ? int'(sb.warn_temp) : int'(sb.crit_temp);
				t = thr + int'($urandom_range(600)) - 300;
				if (t > 32767) t = 32767;
				if (t < -32768) t = -32768;
			end
			pick = $urandom_range(99);
			if (pick < 4)
				clock_ms = $urandom();
			else if (pick < 8)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(2000);
			else
				clock_ms = clock_ms + $urandom_range(span);
			send_item(make_step(t, clock_ms, $urandom_range(99) < 35));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps under the reset thresholds: 6000/5000 critical, 4000/5000 warning.
		send_item(make_step(0, 32'd0, 1'b0));
		send_item(make_step(0, 32'd10, 1'b1));
		// Warning timer arms at timestamp zero, then a cool sample leaves it armed.
		send_item(make_step(4500, 32'd0, 1'b0));
		send_item(make_step(3000, 32'd3000, 1'b0));
		send_item(make_step(4500, 32'd5000, 1'b0));
		send_item(make_step(4500, 32'd5001, 1'b0));
		// Critical arms while in pre-alarm; advance returns to idle.
		send_item(make_step(7000, 32'd5100, 1'b0));
		send_item(make_step(0, 32'd6000, 1'b1));
		send_item(make_step(0, 32'd6001, 1'b1));
		send_item(make_step(7000, 32'd10102, 1'b0));
		send_item(make_step(32767, 32'd20000, 1'b0));
		send_item(make_step(-32768, 32'd20001, 1'b1));
		send_item(make_step(0, 32'd20002, 1'b1));
		// Both timers arm just before the timestamp wraps.
		send_item(make_step(32767, 32'hFFFF_FF00, 1'b0));
		send_item(make_step(32767, 32'h0000_1400, 1'b0));
		send_item(make_step(0, 32'h0000_1400, 1'b1));
		send_item(make_step(5000, 32'h0000_1401, 1'b0));
		send_item(make_step(0, 32'h0000_1402, 1'b1));
		send_item(make_step(0, 32'h0000_1403, 1'b1));
		send_item(make_step(0, 32'h0000_1404, 1'b1));
		send_item(make_step(-1, 32'hFFFF_FFFF, 1'b1));

		run_phase(2000, 32'd300, 1000, 32'd200, 1'b0, 1'b0);
		run_phase(-32768, 32'd0, -32768, 32'd0, 1'b1, 1'b0);
		run_phase(32767, 32'hFFFF_FFFF, 32767, 32'hFFFF_FFFF, 1'b0, 1'b1);
		run_phase(0, 32'd1000, -2000, 32'd500, 1'b1, 1'b0);
		run_phase(int'($urandom_range(8000)) - 1000, $urandom_range(3000),
			int'($urandom_range(4000)) - 3000, $urandom_range(3000), 1'b0, 1'b0);

		drain();
		repeat (10) @(posedge clk);

		$display("Checked %0d results from %0d steps over %0d register settings.",
			sb.checked, sent, phases + 1);
		$display("Predicted %0d alarm and %0d pre-alarm entries.", sb.alarms, sb.prealarms);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d errors, %0d results outstanding", sb.mismatches,
				sb.expected_q.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
